// File: rtl/core/dnr_pkg.sv
// ============================================================================
// dnr_pkg
// Shared types, constants and checksum helpers for the DNS redirect NAT block.
// ============================================================================
package dnr_pkg;

  // Default depth of the query source-port ring.
  localparam int RING_DEPTH_DEF = 16;

  localparam logic [15:0] DNS_PORT  = 16'd53;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  // Register reset values (10.0.0.1, 8.8.8.8, 8.8.4.4, 208.67.222.222,
  // 208.67.220.220).
  localparam logic [31:0] LOCAL_ADDR_RST = 32'h0A00_0001;
  localparam logic [31:0] UP_A_RST       = 32'h0808_0808;
  localparam logic [31:0] UP_B_RST       = 32'h0808_0404;
  localparam logic [31:0] UP_C_RST       = 32'hD043_DEDE;
  localparam logic [31:0] UP_D_RST       = 32'hD043_DCDC;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_A       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP_B       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UP_C       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_D       = 3'd4;

  // Action codes of a result item.
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_REPLY = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0]       local_addr;
    logic [3:0][31:0]  upstream;
  } dnr_cfg_t;

  // Ones-complement fold of a sum of up to eight 16-bit terms.
  function automatic logic [15:0] csum_fold(input logic [18:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = 17'(s[15:0]) + 17'(s[18:16]);
    u = 17'(t[15:0]) + 17'(t[16]);
    return u[15:0];
  endfunction

  // Incremental checksum update for a 32-bit field that changes from old_v
  // to new_v (HC' = ~(~HC + ~m + m')).
  function automatic logic [15:0] csum_replace32(input logic [15:0] hc,
                                                 input logic [31:0] old_v,
                                                 input logic [31:0] new_v);
    logic [15:0] nhc;
    logic [15:0] nold_hi;
    logic [15:0] nold_lo;
    logic [18:0] s;
    nhc     = ~hc;
    nold_hi = ~old_v[31:16];
    nold_lo = ~old_v[15:0];
    s = 19'(nhc) + 19'(nold_hi) + 19'(nold_lo) + 19'(new_v[31:16]) + 19'(new_v[15:0]);
    return ~csum_fold(s);
  endfunction

  // Folded UDP pseudo-header sum (not complemented).
  function automatic logic [15:0] udp_seed(input logic [31:0] saddr,
                                           input logic [31:0] daddr,
                                           input logic [15:0] ulen);
    logic [18:0] s;
    s = 19'(saddr[31:16]) + 19'(saddr[15:0]) + 19'(daddr[31:16]) + 19'(daddr[15:0])
      + 19'(PROTO_UDP) + 19'(ulen);
    return csum_fold(s);
  endfunction

endpackage

// File: rtl/core/dns_redirect_nat.sv
// ============================================================================
// dns_redirect_nat
// UDP DNS NAT with round-robin redirection of queries to four upstreams.
// ============================================================================
// Each input item summarizes one IPv4 header. A leaving UDP query to port 53
// at the local resolver address goes to the next upstream server in turn, with
// a patched checksum and the UDP pseudo-header sum, and its source port enters
// a ring. An arriving UDP packet from port 53 whose destination port is in the
// ring gets the local address as its source; the reply count rises once per
// matching entry. Every item gives one result item. Channels: in_valid/in_stall
// and out_valid/out_stall move an item on an edge with valid high and stall
// low. The user must make cfg_valid/cfg_ready (always ready) writes only
// while idle; the block does not enforce it. An item that needs no ring
// lookup goes from IDLE to FINISH and enters the output register once it is
// free; it can leave when the next item is taken. A DNS reply sweeps the ring
// through its one read port, an entry a cycle, in SCAN before DRAIN. A new
// item is taken while the last result waits; an output stall holds only the
// finished item. Reset clears the ring valid flags, indexes and reply counter
// and loads the register defaults; no clearing pass is needed.
// ============================================================================
module dns_redirect_nat #(
  parameter int RING_DEPTH = dnr_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dnr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [7:0]                    in_protocol,
  input  logic [3:0]                    in_header_words,
  input  logic [15:0]                   in_packet_length,
  input  logic [31:0]                   in_src_addr,
  input  logic [31:0]                   in_dst_addr,
  input  logic [15:0]                   in_src_port,
  input  logic [15:0]                   in_dst_port,
  input  logic [15:0]                   in_ip_checksum,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_action,
  output logic [31:0]                   out_new_src_addr,
  output logic [31:0]                   out_new_dst_addr,
  output logic [15:0]                   out_new_ip_checksum,
  output logic [15:0]                   out_udp_check_seed,
  output logic [31:0]                   out_reply_count
);

  // Ring index width; a one-entry ring still uses a one-bit index.
  localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int HIT_W = $clog2(RING_DEPTH + 1);

  dnr_pkg::dnr_cfg_t cfg;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [15:0]      mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [15:0]      mem_rd_data;
  logic             mem_rd_vld;

  dnr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The ring is written only when a query finishes and read only during a
  // reply sweep; the two never overlap, so no forwarding is required.
  dnr_ring_mem #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .rd_vld  (mem_rd_vld)
  );

  dnr_engine #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W),
    .HIT_W      (HIT_W)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_protocol         (in_protocol),
    .in_header_words     (in_header_words),
    .in_packet_length    (in_packet_length),
    .in_src_addr         (in_src_addr),
    .in_dst_addr         (in_dst_addr),
    .in_src_port         (in_src_port),
    .in_dst_port         (in_dst_port),
    .in_ip_checksum      (in_ip_checksum),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_new_src_addr    (out_new_src_addr),
    .out_new_dst_addr    (out_new_dst_addr),
    .out_new_ip_checksum (out_new_ip_checksum),
    .out_udp_check_seed  (out_udp_check_seed),
    .out_reply_count     (out_reply_count),
    .mem_wr_en           (mem_wr_en),
    .mem_wr_addr         (mem_wr_addr),
    .mem_wr_data         (mem_wr_data),
    .mem_rd_en           (mem_rd_en),
    .mem_rd_addr         (mem_rd_addr),
    .mem_rd_data         (mem_rd_data),
    .mem_rd_vld          (mem_rd_vld)
  );

endmodule

// File: rtl/core/dnr_cfg_regs.sv
// ============================================================================
// dnr_cfg_regs
// Configuration register file: local resolver and four upstream addresses.
// ============================================================================
module dnr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dnr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output dnr_pkg::dnr_cfg_t             cfg
);

  dnr_pkg::dnr_cfg_t cfg_r;

  // Writes are taken at once, so the port never holds off.
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_addr  <= dnr_pkg::LOCAL_ADDR_RST;
      cfg_r.upstream[0] <= dnr_pkg::UP_A_RST;
      cfg_r.upstream[1] <= dnr_pkg::UP_B_RST;
      cfg_r.upstream[2] <= dnr_pkg::UP_C_RST;
      cfg_r.upstream[3] <= dnr_pkg::UP_D_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        dnr_pkg::REG_LOCAL_ADDR: cfg_r.local_addr  <= cfg_data;
        dnr_pkg::REG_UP_A:       cfg_r.upstream[0] <= cfg_data;
        dnr_pkg::REG_UP_B:       cfg_r.upstream[1] <= cfg_data;
        dnr_pkg::REG_UP_C:       cfg_r.upstream[2] <= cfg_data;
        dnr_pkg::REG_UP_D:       cfg_r.upstream[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/dnr_ring_mem.sv
// ============================================================================
// dnr_ring_mem
// Port ring storage: one write port, one registered read port, valid bits.
// ============================================================================
module dnr_ring_mem #(
  parameter int RING_DEPTH = dnr_pkg::RING_DEPTH_DEF,
  parameter int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [15:0]      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [15:0]      rd_data,
  output logic             rd_vld
);

  logic [15:0]           ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_r;
  logic [15:0]           rd_data_r;
  logic                  rd_vld_r;

  assign rd_data = rd_data_r;
  assign rd_vld  = rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // Entries never written since reset must not match, so each has a flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

endmodule

// File: rtl/core/dnr_engine.sv
// ============================================================================
// dnr_engine
// Classifies each item, sweeps the port ring for replies, builds the result.
// ============================================================================
module dnr_engine #(
  parameter int RING_DEPTH = dnr_pkg::RING_DEPTH_DEF,
  parameter int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  parameter int HIT_W      = $clog2(RING_DEPTH + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dnr_pkg::dnr_cfg_t       cfg,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [7:0]              in_protocol,
  input  logic [3:0]              in_header_words,
  input  logic [15:0]             in_packet_length,
  input  logic [31:0]             in_src_addr,
  input  logic [31:0]             in_dst_addr,
  input  logic [15:0]             in_src_port,
  input  logic [15:0]             in_dst_port,
  input  logic [15:0]             in_ip_checksum,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_action,
  output logic [31:0]             out_new_src_addr,
  output logic [31:0]             out_new_dst_addr,
  output logic [15:0]             out_new_ip_checksum,
  output logic [15:0]             out_udp_check_seed,
  output logic [31:0]             out_reply_count,
  output logic                    mem_wr_en,
  output logic [IDX_W-1:0]        mem_wr_addr,
  output logic [15:0]             mem_wr_data,
  output logic                    mem_rd_en,
  output logic [IDX_W-1:0]        mem_rd_addr,
  input  logic [15:0]             mem_rd_data,
  input  logic                    mem_rd_vld
);

  dnr_pkg::state_t state_r, state_nxt;

  // Item held while it is worked on.
  logic        query_r, rcand_r;
  logic [31:0] saddr_r, daddr_r;
  logic [15:0] sport_r, dport_r, hc_r, ulen_r;

  // Control state.
  logic [IDX_W-1:0] scan_idx_r;
  logic             cmp_v_r;
  logic [HIT_W-1:0] hits_r;
  logic [IDX_W-1:0] wr_idx_r;
  logic [1:0]       rr_r;
  logic [31:0]      reply_cnt_r, reply_cnt_nxt;

  // Output register.
  logic        out_valid_r;
  logic [1:0]  action_r;
  logic [31:0] nsrc_r, ndst_r;
  logic [15:0] nhc_r, seed_r;

  logic accept, out_free, scan_last, done, hit;
  logic is_query_in, is_rcand_in;

  logic        reply_hit;
  logic [31:0] ups_sel, old_addr, new_addr;
  logic [1:0]  act_nxt;
  logic [31:0] nsrc_nxt, ndst_nxt;
  logic [15:0] nhc_nxt, seed_nxt;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_last = (scan_idx_r == IDX_W'(RING_DEPTH - 1));
  assign hit       = cmp_v_r && mem_rd_vld && (mem_rd_data == dport_r);

  assign is_query_in = in_op && (in_protocol == dnr_pkg::PROTO_UDP)
                    && (in_dst_port == dnr_pkg::DNS_PORT)
                    && (in_dst_addr == cfg.local_addr);
  assign is_rcand_in = !in_op && (in_protocol == dnr_pkg::PROTO_UDP)
                    && (in_src_port == dnr_pkg::DNS_PORT);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dnr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = is_rcand_in ? dnr_pkg::ST_SCAN : dnr_pkg::ST_FINISH;
        end
      end
      dnr_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_nxt = dnr_pkg::ST_DRAIN;
        end
      end
      dnr_pkg::ST_DRAIN: begin
        state_nxt = dnr_pkg::ST_FINISH;
      end
      dnr_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = dnr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dnr_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall  = 1'b1;
    mem_rd_en = 1'b0;
    done      = 1'b0;
    case (state_r)
      dnr_pkg::ST_IDLE:   in_stall  = 1'b0;
      dnr_pkg::ST_SCAN:   mem_rd_en = 1'b1;
      dnr_pkg::ST_DRAIN:  done      = 1'b0;
      dnr_pkg::ST_FINISH: done      = out_free;
      default:            in_stall  = 1'b1;
    endcase
  end

  assign mem_rd_addr = scan_idx_r;
  assign mem_wr_en   = done && query_r;
  assign mem_wr_addr = wr_idx_r;
  assign mem_wr_data = sport_r;

  // Result of the held item.
  assign reply_hit = rcand_r && (hits_r != '0);
  assign ups_sel   = cfg.upstream[rr_r];
  assign old_addr  = query_r ? daddr_r : saddr_r;
  assign new_addr  = query_r ? ups_sel : cfg.local_addr;

  always_comb begin
    act_nxt  = dnr_pkg::ACT_NONE;
    nsrc_nxt = saddr_r;
    ndst_nxt = daddr_r;
    nhc_nxt  = hc_r;
    seed_nxt = '0;
    if (query_r) begin
      act_nxt  = dnr_pkg::ACT_QUERY;
      ndst_nxt = ups_sel;
      nhc_nxt  = dnr_pkg::csum_replace32(hc_r, old_addr, new_addr);
      seed_nxt = dnr_pkg::udp_seed(saddr_r, ups_sel, ulen_r);
    end else if (reply_hit) begin
      act_nxt  = dnr_pkg::ACT_REPLY;
      nsrc_nxt = cfg.local_addr;
      nhc_nxt  = dnr_pkg::csum_replace32(hc_r, old_addr, new_addr);
    end
  end

  // hits_r stays zero for every item that is not swept.
  assign reply_cnt_nxt = reply_cnt_r + 32'(hits_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnr_pkg::ST_IDLE;
      scan_idx_r  <= '0;
      cmp_v_r     <= 1'b0;
      hits_r      <= '0;
      wr_idx_r    <= '0;
      rr_r        <= '0;
      reply_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cmp_v_r <= mem_rd_en;
      if (accept) begin
        scan_idx_r <= '0;
        hits_r     <= '0;
      end else begin
        if (mem_rd_en && !scan_last) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (hit) begin
          hits_r <= hits_r + 1'b1;
        end
      end
      if (done) begin
        out_valid_r <= 1'b1;
        reply_cnt_r <= reply_cnt_nxt;
        if (query_r) begin
          rr_r     <= rr_r + 2'd1;
          wr_idx_r <= (wr_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_r + 1'b1;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query_r <= is_query_in;
      rcand_r <= is_rcand_in;
      saddr_r <= in_src_addr;
      daddr_r <= in_dst_addr;
      sport_r <= in_src_port;
      dport_r <= in_dst_port;
      hc_r    <= in_ip_checksum;
      ulen_r  <= in_packet_length - {10'd0, in_header_words, 2'b00};
    end
    if (done) begin
      action_r <= act_nxt;
      nsrc_r   <= nsrc_nxt;
      ndst_r   <= ndst_nxt;
      nhc_r    <= nhc_nxt;
      seed_r   <= seed_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = action_r;
  assign out_new_src_addr    = nsrc_r;
  assign out_new_dst_addr    = ndst_r;
  assign out_new_ip_checksum = nhc_r;
  assign out_udp_check_seed  = seed_r;
  assign out_reply_count     = reply_cnt_r;

endmodule

// File: test/dns_redirect_nat_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// dns_redirect_nat_tb
// Self-checking testbench for the DNS redirect NAT block.
// ============================================================================
// A driver feeds IPv4 header summaries from a queue of pending items. A
// monitor compares every result with the rewrite predicted when its item was
// accepted. The predictor keeps its own copy of the port ring, the
// round-robin pointer, the reply counter and the address registers. The run
// starts with a short directed part that covers the empty ring, short
// packets, repeated ports and ring wrap. It goes on through random phases
// that each use their own register setting and one of four patterns of
// sender idling and receiver stalls.
// ============================================================================
module dns_redirect_nat_tb;

  localparam int RING_SLOTS = dnr_pkg::RING_DEPTH_DEF;
  // A DNS reply sweeps the ring, so it is the slowest item.
  localparam int HOLD_CYCLES = RING_SLOTS + 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_ITEMS = 192;
  localparam int NUM_PHASES = 8;

  // Direction codes of an input item.
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_LEAVE  = 1'b1;

  // Register indexes above the last register are spare and must be ignored.
  localparam logic [dnr_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = dnr_pkg::REG_UP_D + 1'b1;
  localparam logic [dnr_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  protocol;
    logic [3:0]  header_words;
    logic [15:0] packet_length;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] ip_checksum;
  } pkt_hdr_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ip_checksum;
    logic [15:0] udp_seed;
    logic [31:0] reply_count;
  } nat_rewrite_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [dnr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_op = 1'b0;
  logic [7:0]                    in_protocol = '0;
  logic [3:0]                    in_header_words = 4'd5;
  logic [15:0]                   in_packet_length = '0;
  logic [31:0]                   in_src_addr = '0;
  logic [31:0]                   in_dst_addr = '0;
  logic [15:0]                   in_src_port = '0;
  logic [15:0]                   in_dst_port = '0;
  logic [15:0]                   in_ip_checksum = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [1:0]                    out_action;
  logic [31:0]                   out_new_src_addr;
  logic [31:0]                   out_new_dst_addr;
  logic [15:0]                   out_new_ip_checksum;
  logic [15:0]                   out_udp_check_seed;
  logic [31:0]                   out_reply_count;

  // Items waiting to be driven, and the rewrites expected for accepted items.
  pkt_hdr_t     pending_hdrs[$];
  nat_rewrite_t expected_rewrites[$];
  pkt_hdr_t     cur_hdr;

  // Predictor state: a private copy of the registers and of the block state.
  logic [31:0]                   cfg_local = dnr_pkg::LOCAL_ADDR_RST;
  logic [31:0]                   cfg_upstream[4] = '{dnr_pkg::UP_A_RST, dnr_pkg::UP_B_RST,
                                                     dnr_pkg::UP_C_RST, dnr_pkg::UP_D_RST};
  logic [15:0]                   port_ring[RING_SLOTS];
  logic                          ring_used[RING_SLOTS];
  logic [$clog2(RING_SLOTS)-1:0] ring_wr = '0;
  logic [1:0]                    rr_next = '0;
  logic [31:0]                   replies_seen = '0;

  // Source ports of the latest queries, used to aim replies at the ring.
  logic [15:0] recent_ports[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  dns_redirect_nat u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_protocol         (in_protocol),
    .in_header_words     (in_header_words),
    .in_packet_length    (in_packet_length),
    .in_src_addr         (in_src_addr),
    .in_dst_addr         (in_dst_addr),
    .in_src_port         (in_src_port),
    .in_dst_port         (in_dst_port),
    .in_ip_checksum      (in_ip_checksum),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_new_src_addr    (out_new_src_addr),
    .out_new_dst_addr    (out_new_dst_addr),
    .out_new_ip_checksum (out_new_ip_checksum),
    .out_udp_check_seed  (out_udp_check_seed),
    .out_reply_count     (out_reply_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Checksum arithmetic
  // --------------------------------------------------------------------------

  // Ones-complement fold of a 32-bit sum down to 16 bits.
  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [31:0] t;
    t = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
    return t[15:0];
  endfunction

  // Patch a header checksum for a 32-bit field that goes from was_v to new_v.
  // The complements are taken at 16 bits before any widening.
  function automatic logic [15:0] csum_patch(input logic [15:0] hc,
                                             input logic [31:0] was_v,
                                             input logic [31:0] new_v);
    logic [15:0] inv_hc;
    logic [15:0] inv_hi;
    logic [15:0] inv_lo;
    logic [31:0] acc;
    inv_hc = ~hc;
    inv_hi = ~was_v[31:16];
    inv_lo = ~was_v[15:0];
    acc = 32'(inv_hc) + 32'(inv_hi) + 32'(inv_lo) + 32'(new_v[31:16]) + 32'(new_v[15:0]);
    return ~fold16(acc);
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: works out the rewrite of one accepted item and updates the
  // ring, the round-robin pointer and the reply counter as the block does.
  // --------------------------------------------------------------------------
  task automatic predict_rewrite(input pkt_hdr_t p, output nat_rewrite_t r);
    logic [15:0] udp_len;
    logic [31:0] seed_sum;
    int          hits;
    r.action      = dnr_pkg::ACT_NONE;
    r.src_addr    = p.src_addr;
    r.dst_addr    = p.dst_addr;
    r.ip_checksum = p.ip_checksum;
    r.udp_seed    = '0;
    if (p.op == OP_LEAVE) begin
      if (p.protocol == dnr_pkg::PROTO_UDP && p.dst_port == dnr_pkg::DNS_PORT
          && p.dst_addr == cfg_local) begin
        // The UDP length wraps when the packet is shorter than its IP header.
        udp_len = p.packet_length - {10'd0, p.header_words, 2'b00};
        r.dst_addr = cfg_upstream[rr_next];
        rr_next = rr_next + 2'd1;
        // The patch is applied even when the new address equals the old one.
        r.ip_checksum = csum_patch(p.ip_checksum, p.dst_addr, r.dst_addr);
        seed_sum = 32'(p.src_addr[31:16]) + 32'(p.src_addr[15:0])
                 + 32'(r.dst_addr[31:16]) + 32'(r.dst_addr[15:0])
                 + 32'(dnr_pkg::PROTO_UDP) + 32'(udp_len);
        r.udp_seed = fold16(seed_sum);
        // A full ring overwrites its oldest entry.
        port_ring[ring_wr] = p.src_port;
        ring_used[ring_wr] = 1'b1;
        ring_wr = ring_wr + 1'b1;
        r.action = dnr_pkg::ACT_QUERY;
      end
    end else if (p.protocol == dnr_pkg::PROTO_UDP && p.src_port == dnr_pkg::DNS_PORT) begin
      // Entries never written since reset do not match, not even port 0.
      hits = 0;
      for (int i = 0; i < RING_SLOTS; i++) begin
        if (ring_used[i] && port_ring[i] == p.dst_port) hits++;
      end
      if (hits != 0) begin
        replies_seen = replies_seen + 32'(hits);
        r.src_addr = cfg_local;
        r.ip_checksum = csum_patch(p.ip_checksum, p.src_addr, cfg_local);
        r.action = dnr_pkg::ACT_REPLY;
      end
    end
    r.reply_count = replies_seen;
  endtask

  // --------------------------------------------------------------------------
  // Error reporting
  // --------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (err_count < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver. When the current item is taken (or none is shown), the next one
  // is shown unless the sender idles this cycle. A shown item stays put, with
  // in_valid high, until the block takes it. The item is predicted at the
  // edge where it is accepted, so the expectations stay in item order.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    nat_rewrite_t rw;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_rewrite(cur_hdr, rw);
        expected_rewrites.push_back(rw);
      end
      if (!in_valid || !in_stall) begin
        if (pending_hdrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_hdr = pending_hdrs.pop_front();
          in_op            <= cur_hdr.op;
          in_protocol      <= cur_hdr.protocol;
          in_header_words  <= cur_hdr.header_words;
          in_packet_length <= cur_hdr.packet_length;
          in_src_addr      <= cur_hdr.src_addr;
          in_dst_addr      <= cur_hdr.dst_addr;
          in_src_port      <= cur_hdr.src_port;
          in_dst_port      <= cur_hdr.dst_port;
          in_ip_checksum   <= cur_hdr.ip_checksum;
          in_valid         <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. A result is taken at an edge where out_valid is high and our
  // stall is low. The stall for the next cycle is drawn at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    nat_rewrite_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rewrites.size() == 0) begin
          flag_error($sformatf("result with no item pending, action %0d", out_action));
        end else begin
          want = expected_rewrites.pop_front();
          check_field("action", 32'(out_action), 32'(want.action));
          check_field("new_src_addr", out_new_src_addr, want.src_addr);
          check_field("new_dst_addr", out_new_dst_addr, want.dst_addr);
          check_field("new_ip_checksum", 32'(out_new_ip_checksum), 32'(want.ip_checksum));
          check_field("udp_check_seed", 32'(out_udp_check_seed), 32'(want.udp_seed));
          check_field("reply_count", out_reply_count, want.reply_count);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog. The run ends as failed when nothing moves on any channel for
  // too long. The slowest item, a reply with many receiver stalls, stays far
  // below the limit.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Writes one register and, once the write is taken, updates the predictor.
  // Writes to a spare index are ignored by the block and by the predictor.
  task automatic write_reg(input logic [dnr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      dnr_pkg::REG_LOCAL_ADDR: cfg_local = value;
      dnr_pkg::REG_UP_A:       cfg_upstream[0] = value;
      dnr_pkg::REG_UP_B:       cfg_upstream[1] = value;
      dnr_pkg::REG_UP_C:       cfg_upstream[2] = value;
      dnr_pkg::REG_UP_D:       cfg_upstream[3] = value;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [31:0] local_a, input logic [31:0] up_a,
                              input logic [31:0] up_b, input logic [31:0] up_c,
                              input logic [31:0] up_d);
    write_reg(dnr_pkg::REG_LOCAL_ADDR, local_a);
    write_reg(dnr_pkg::REG_UP_A, up_a);
    write_reg(dnr_pkg::REG_UP_B, up_b);
    write_reg(dnr_pkg::REG_UP_C, up_c);
    write_reg(dnr_pkg::REG_UP_D, up_d);
    write_reg(dnr_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
              $urandom);
  endtask

  // The sender pauses here until every expected result has come, and then
  // lets the block settle before any register is touched.
  task automatic wait_drained();
    while (pending_hdrs.size() != 0 || in_valid || expected_rewrites.size() != 0)
      @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 63; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 63; end
      IDLE_BOTH: begin send_idle_pct = 22; recv_stall_pct = 22; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  function automatic pkt_hdr_t make_hdr(input logic op, input logic [7:0] protocol,
                                        input logic [3:0] hw, input logic [15:0] plen,
                                        input logic [31:0] sa, input logic [31:0] da,
                                        input logic [15:0] sp, input logic [15:0] dp,
                                        input logic [15:0] hc);
    pkt_hdr_t p;
    p.op = op;
    p.protocol = protocol;
    p.header_words = hw;
    p.packet_length = plen;
    p.src_addr = sa;
    p.dst_addr = da;
    p.src_port = sp;
    p.dst_port = dp;
    p.ip_checksum = hc;
    return p;
  endfunction

  // Every field random. One packet in five is short enough that the UDP
  // length can wrap.
  function automatic pkt_hdr_t random_hdr();
    pkt_hdr_t p;
    p.op = 1'($urandom);
    p.protocol = 8'($urandom);
    p.header_words = 4'($urandom_range(5, 15));
    p.packet_length = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 64)) : 16'($urandom);
    p.src_addr = $urandom;
    p.dst_addr = $urandom;
    p.src_port = 16'($urandom);
    p.dst_port = 16'($urandom);
    p.ip_checksum = 16'($urandom);
    return p;
  endfunction

  function automatic logic [15:0] pick_recent_port();
    if (recent_ports.size() == 0) return 16'($urandom);
    return recent_ports[$urandom_range(0, recent_ports.size() - 1)];
  endfunction

  // Mostly well-formed queries and replies aimed at ports in the ring, the
  // rest near misses (one condition broken) and pure noise.
  function automatic pkt_hdr_t gen_random_hdr();
    pkt_hdr_t p;
    int       pick;
    int       bit_k;
    p = random_hdr();
    pick = $urandom_range(0, 99);
    bit_k = $urandom_range(0, 31);
    if (pick < 40) begin
      p.op = OP_LEAVE;
      p.protocol = dnr_pkg::PROTO_UDP;
      p.dst_port = dnr_pkg::DNS_PORT;
      p.dst_addr = cfg_local;
      // A small pool of ports makes repeated ring entries and multiple hits.
      if ($urandom_range(0, 1) == 0) p.src_port = 16'($urandom_range(0, 7));
      recent_ports.push_back(p.src_port);
      if (recent_ports.size() > RING_SLOTS) void'(recent_ports.pop_front());
    end else if (pick < 75) begin
      p.op = OP_ARRIVE;
      p.protocol = dnr_pkg::PROTO_UDP;
      p.src_port = dnr_pkg::DNS_PORT;
      if ($urandom_range(0, 9) < 8) p.dst_port = pick_recent_port();
      if ($urandom_range(0, 9) == 0) p.src_addr = cfg_local;
    end else if (pick < 90) begin
      p.protocol = dnr_pkg::PROTO_UDP;
      if (p.op == OP_LEAVE) begin
        p.dst_port = dnr_pkg::DNS_PORT;
        p.dst_addr = cfg_local;
      end else begin
        p.src_port = dnr_pkg::DNS_PORT;
        p.dst_port = pick_recent_port();
      end
      case ($urandom_range(0, 2))
        0: p.protocol = p.protocol ^ (8'd1 << (bit_k % 8));
        1: begin
          if (p.op == OP_LEAVE) p.dst_port = p.dst_port ^ (16'd1 << (bit_k % 16));
          else p.src_port = p.src_port ^ (16'd1 << (bit_k % 16));
        end
        default: begin
          if (p.op == OP_LEAVE) p.dst_addr = p.dst_addr ^ (32'd1 << bit_k);
          else p.op = OP_LEAVE;
        end
      endcase
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    idle_mode_t  mode;
    logic [31:0] addr;
    for (int i = 0; i < RING_SLOTS; i++) begin
      port_ring[i] = '0;
      ring_used[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the registers at their reset values.
    // A reply to port 0 while the ring is empty must pass untouched.
    pending_hdrs.push_back(make_hdr(OP_ARRIVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd60,
                                    32'h0808_0808, 32'hC0A8_0102, dnr_pkg::DNS_PORT,
                                    16'd0, 16'h1C2B));
    // A query from port 0 in a zero-length packet: the UDP length wraps.
    pending_hdrs.push_back(make_hdr(OP_LEAVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd0, 32'h0,
                                    cfg_local, 16'd0, dnr_pkg::DNS_PORT, 16'h0));
    // Now port 0 is in the ring, so the same reply matches.
    pending_hdrs.push_back(make_hdr(OP_ARRIVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd40,
                                    32'hFFFF_FFFF, 32'hC0A8_0102, dnr_pkg::DNS_PORT,
                                    16'd0, 16'hFFFF));
    // Two queries from the top port, one long and one short, then a reply
    // that hits both entries at once.
    pending_hdrs.push_back(make_hdr(OP_LEAVE, dnr_pkg::PROTO_UDP, 4'd15, 16'hFFFF,
                                    32'hFFFF_FFFF, cfg_local, 16'hFFFF,
                                    dnr_pkg::DNS_PORT, 16'hFFFF));
    pending_hdrs.push_back(make_hdr(OP_LEAVE, dnr_pkg::PROTO_UDP, 4'd15, 16'd59,
                                    32'hFFFF_FFFF, cfg_local, 16'hFFFF,
                                    dnr_pkg::DNS_PORT, 16'h8000));
    pending_hdrs.push_back(make_hdr(OP_ARRIVE, dnr_pkg::PROTO_UDP, 4'd15, 16'hFFFF, 32'h0,
                                    32'hFFFF_FFFF, dnr_pkg::DNS_PORT, 16'hFFFF, 16'h0));
    // Fourteen more queries fill the ring and wrap, overwriting port 0.
    for (int i = 0; i < 14; i++) begin
      pending_hdrs.push_back(make_hdr(OP_LEAVE, dnr_pkg::PROTO_UDP,
                                      4'($urandom_range(5, 15)), 16'($urandom), $urandom,
                                      cfg_local, 16'h1234, dnr_pkg::DNS_PORT,
                                      16'($urandom)));
    end
    pending_hdrs.push_back(make_hdr(OP_ARRIVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd80, $urandom,
                                    $urandom, dnr_pkg::DNS_PORT, 16'd0, 16'($urandom)));
    pending_hdrs.push_back(make_hdr(OP_ARRIVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd80, $urandom,
                                    $urandom, dnr_pkg::DNS_PORT, 16'h1234, 16'($urandom)));
    // Near misses: not UDP, wrong source port on a reply, wrong address.
    pending_hdrs.push_back(make_hdr(OP_LEAVE, 8'd6, 4'd5, 16'd80, $urandom,
                                    cfg_local, 16'h1234, dnr_pkg::DNS_PORT,
                                    16'($urandom)));
    pending_hdrs.push_back(make_hdr(OP_ARRIVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd80, $urandom,
                                    $urandom, dnr_pkg::DNS_PORT + 16'd1, 16'h1234,
                                    16'($urandom)));
    pending_hdrs.push_back(make_hdr(OP_LEAVE, dnr_pkg::PROTO_UDP, 4'd5, 16'd80, $urandom,
                                    cfg_local ^ 32'd1, 16'h1234, dnr_pkg::DNS_PORT,
                                    16'($urandom)));
    wait_drained();

    // Random phases, each with its own register setting and idling pattern.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;  // keep the reset values
        2: program_regs('0, '0, '0, '0, '0);
        3: program_regs('1, '1, '1, '1, '1);
        4: begin
          // The first upstream equals the local address, so that rewrite
          // leaves the address as it was.
          addr = $urandom;
          program_regs(addr, addr, 32'h0, 32'hFFFF_FFFF, $urandom);
        end
        default: program_regs($urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      mode = idle_mode_t'((ph + 1) % 4);
      set_idling(mode);
      for (int i = 0; i < PHASE_ITEMS; i++) pending_hdrs.push_back(gen_random_hdr());
      wait_drained();
    end

    if (expected_rewrites.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_rewrites.size()));
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
